>>> hdl/assert_macros.svh
// Assertion macros shared by the ARP cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/arp_pkg.sv
// Shared types and constants for the ARP cache and responder.
package arp_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;

  localparam int IN_W  = 192;
  localparam int OUT_W = 184;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP = 1'd1;

  localparam logic [10:0] MIN_ARP_LEN    = 11'd28;
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
  localparam logic [7:0]  PLEN_IPV4      = 8'd4;
  localparam logic [15:0] ARP_OP_REQ     = 16'd1;
  localparam logic [15:0] ARP_OP_REP     = 16'd2;
  localparam logic [1:0]  FRAME_OP_REQ   = 2'd1;
  localparam logic [1:0]  FRAME_OP_REP   = 2'd2;
  localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_INBOUND = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_REQUEST = 2'd2,
    OP_UNDEF   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RC_LEARNED     = 3'd0,
    RC_LEARN_REPLY = 3'd1,
    RC_RUNT        = 3'd2,
    RC_UNSUPPORTED = 3'd3,
    RC_UNKNOWN_OP  = 3'd4,
    RC_HIT         = 3'd5,
    RC_MISS        = 3'd6,
    RC_REQUEST     = 3'd7
  } result_code_t;

  // What the back end has to do with a command.
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_LEARN  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t    kind;
    result_code_t code;
    logic [31:0]  ip;
    logic [47:0]  mac;
  } cmd_t;

  // Input beat, operation in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] target_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [15:0] arp_opcode;
    logic [7:0]  proto_addr_len;
    logic [7:0]  hw_addr_len;
    logic [15:0] proto_type;
    logic [15:0] hw_type;
    logic [10:0] payload_length;
    op_t         operation;
  } in_item_t;

  // Result beat, result_code in the lowest bits.
  typedef struct packed {
    logic         pad;
    logic         evicted_first;
    logic [47:0]  lookup_mac;
    logic [31:0]  frame_target_ip;
    logic [47:0]  frame_target_mac;
    logic [1:0]   frame_opcode;
    logic [47:0]  frame_dest_mac;
    logic         send_frame;
    result_code_t result_code;
  } out_item_t;

  // Queue read handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    logic pop;
  } fifo_rd_t;

endpackage

>>> hdl/arp_cache_responder.sv
// ARP cache and responder for IPv4 over Ethernet: top level.
// Runt, unsupported and send-request beats go via the command queue to the result
// register; lookups and learns also scan the 16-entry cache first.
// One item at a time in the back end, paced by the one-entry-a-cycle scan and by
// the result being taken; a 2-deep queue lets input run ahead.
// Reset (rst, synchronous): clears all cache valid bits, local_ip, queue, m_tvalid.
module arp_cache_responder (
  input  logic                            clk,
  input  logic                            rst,
  // Input beat. tdata fields, low bit up: operation 2, payload_length 11,
  // hw_type 16, proto_type 16, hw_addr_len 8, proto_addr_len 8,
  // arp_opcode 16, sender_mac 48, sender_ip 32, target_ip 32, zero pad 3.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [arp_pkg::IN_W-1:0]        s_tdata,
  // Result beat. tdata fields, low bit up: result_code 3, send_frame 1,
  // frame_dest_mac 48, frame_opcode 2, frame_target_mac 48,
  // frame_target_ip 32, lookup_mac 48, evicted_first 1, zero pad 1.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [arp_pkg::OUT_W-1:0]       m_tdata,
  // Register writes: index 0 local_mac, 1 local_ip.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic              push;
  logic              fifo_full;
  arp_pkg::cmd_t     cmd_in;
  arp_pkg::cmd_t     cmd_head;
  arp_pkg::fifo_rd_t rd;

  // Front: decode and format check, local_ip compare for replies.
  arp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (cmd_in)
  );

  // Decouples the front from a stalled or scanning back end.
  arp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (fifo_full),
    .pop     (rd.pop),
    .valid   (rd.valid),
    .cmd_out (cmd_head)
  );

  // Back: cache scan and update, result register.
  arp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (rd.valid),
    .head       (cmd_head),
    .pop        (rd.pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> hdl/arp_front.sv
// Front end: accepts input beats, checks format, classifies into commands.
module arp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [arp_pkg::IN_W-1:0]        s_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            fifo_full,
  output logic                            push,
  output arp_pkg::cmd_t                   cmd
);

  arp_pkg::in_item_t item;
  logic [31:0]       local_ip;
  logic              fmt_ok;

  assign item      = arp_pkg::in_item_t'(s_tdata);
  assign s_tready  = !fifo_full;
  assign cfg_ready = 1'b1;

  // local_mac writes are taken but not kept: no result carries it.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (cfg_valid && cfg_index == arp_pkg::REG_LOCAL_IP) begin
      local_ip <= cfg_data[31:0];
    end
  end

  assign fmt_ok = item.hw_type == arp_pkg::HTYPE_ETHERNET &&
                  item.proto_type == arp_pkg::PTYPE_IPV4 &&
                  item.hw_addr_len == arp_pkg::HLEN_ETHERNET &&
                  item.proto_addr_len == arp_pkg::PLEN_IPV4;

  // Undefined operation is taken and dropped.
  assign push = s_tvalid && s_tready && item.operation != arp_pkg::OP_UNDEF;

  always_comb begin
    cmd.kind = arp_pkg::KIND_DIRECT;
    cmd.code = arp_pkg::RC_REQUEST;
    cmd.ip   = item.target_ip;
    cmd.mac  = item.sender_mac;
    case (item.operation)
      arp_pkg::OP_LOOKUP: begin
        cmd.kind = arp_pkg::KIND_LOOKUP;
        cmd.code = arp_pkg::RC_MISS;
      end
      arp_pkg::OP_INBOUND: begin
        cmd.ip = item.sender_ip;
        if (item.payload_length < arp_pkg::MIN_ARP_LEN) begin
          cmd.code = arp_pkg::RC_RUNT;
        end else if (!fmt_ok) begin
          cmd.code = arp_pkg::RC_UNSUPPORTED;
        end else begin
          cmd.kind = arp_pkg::KIND_LEARN;
          if (item.arp_opcode == arp_pkg::ARP_OP_REQ) begin
            cmd.code = (item.target_ip == local_ip) ? arp_pkg::RC_LEARN_REPLY
                                                    : arp_pkg::RC_LEARNED;
          end else if (item.arp_opcode == arp_pkg::ARP_OP_REP) begin
            cmd.code = arp_pkg::RC_LEARNED;
          end else begin
            cmd.code = arp_pkg::RC_UNKNOWN_OP;
          end
        end
      end
      default: begin
        cmd.kind = arp_pkg::KIND_DIRECT;
      end
    endcase
  end

endmodule

>>> hdl/arp_cmd_fifo.sv
// Short command queue between front and back ends.
`include "assert_macros.svh"

module arp_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arp_pkg::cmd_t     cmd_in,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output arp_pkg::cmd_t     cmd_out
);

  arp_pkg::cmd_t                   mem [arp_pkg::FIFO_DEPTH];
  logic [arp_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [arp_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [arp_pkg::FIFO_PTR_W:0]    count;

  assign full    = count == (arp_pkg::FIFO_PTR_W+1)'(arp_pkg::FIFO_DEPTH);
  assign valid   = count != '0;
  assign cmd_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overflow, push, !full || pop, "command queue overflow")
  `ASSERT_IMPL(a_no_underflow, pop, valid, "command queue underflow")

endmodule

>>> hdl/arp_back.sv
// Back end: cache scan, learning, and result beat assembly.
`include "assert_macros.svh"

module arp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  arp_pkg::cmd_t              head,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [arp_pkg::OUT_W-1:0]  m_tdata
);

  localparam int N = arp_pkg::CACHE_ENTRIES;
  localparam int W = arp_pkg::IDX_W;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t              state;
  arp_pkg::cmd_t       cur;
  arp_pkg::cmd_t       src;
  arp_pkg::out_item_t  res;
  arp_pkg::out_item_t  out_q;

  logic [N-1:0]  entry_valid;
  logic [31:0]   entry_ip  [N];
  logic [47:0]   entry_mac [N];

  logic [W:0]    cnt;
  logic [W-1:0]  rd_addr;
  logic          rd_vld;
  logic [W-1:0]  rd_idx;
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;
  logic          hole_found;
  logic [W-1:0]  hole_idx;

  logic          hit;
  logic          last;
  logic          done;
  logic          free_now;
  logic [W-1:0]  slot;
  logic          wr_en;
  logic          wr_new;
  logic [W-1:0]  wr_idx;

  assign rd_addr = cnt[W-1:0];
  assign hit     = rd_vld && entry_valid[rd_idx] && rd_ip == cur.ip;
  assign last    = rd_vld && rd_idx == W'(N-1);
  assign done    = state == ST_SCAN && (hit || last);
  assign free_now = hole_found || (rd_vld && !entry_valid[rd_idx]);
  assign slot     = hole_found ? hole_idx : (free_now ? rd_idx : '0);

  // Single write port: refresh on hit, else fill a hole or overwrite slot 0.
  assign wr_en  = done && cur.kind == arp_pkg::KIND_LEARN;
  assign wr_new = wr_en && !hit;
  assign wr_idx = hit ? rd_idx : slot;

  assign pop     = state == ST_IDLE && head_valid && !m_tvalid;
  assign m_tdata = out_q;

  always_comb begin
    src = (state == ST_IDLE) ? head : cur;
    res = '0;
    res.result_code = src.code;
    case (src.kind)
      arp_pkg::KIND_LOOKUP: begin
        res.result_code = hit ? arp_pkg::RC_HIT : arp_pkg::RC_MISS;
        res.lookup_mac  = hit ? rd_mac : '0;
      end
      arp_pkg::KIND_LEARN: begin
        res.evicted_first = !hit && !free_now;
        if (src.code == arp_pkg::RC_LEARN_REPLY) begin
          res.send_frame       = 1'b1;
          res.frame_dest_mac   = src.mac;
          res.frame_opcode     = arp_pkg::FRAME_OP_REP;
          res.frame_target_mac = src.mac;
          res.frame_target_ip  = src.ip;
        end
      end
      default: begin
        if (src.code == arp_pkg::RC_REQUEST) begin
          res.send_frame      = 1'b1;
          res.frame_dest_mac  = arp_pkg::MAC_BROADCAST;
          res.frame_opcode    = arp_pkg::FRAME_OP_REQ;
          res.frame_target_ip = src.ip;
        end
      end
    endcase
  end

  // Cache payload memory: registered read, one write.
  always_ff @(posedge clk) begin
    rd_ip  <= entry_ip[rd_addr];
    rd_mac <= entry_mac[rd_addr];
    if (wr_en) begin
      entry_mac[wr_idx] <= cur.mac;
    end
    if (wr_new) begin
      entry_ip[wr_idx] <= cur.ip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_new) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      hole_found <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            cur <= head;
            if (head.kind == arp_pkg::KIND_DIRECT) begin
              out_q    <= res;
              m_tvalid <= 1'b1;
            end else begin
              state      <= ST_SCAN;
              cnt        <= '0;
              rd_vld     <= 1'b0;
              hole_found <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          rd_vld <= cnt < (W+1)'(N);
          rd_idx <= rd_addr;
          if (cnt < (W+1)'(N)) cnt <= cnt + 1'b1;
          if (rd_vld && !entry_valid[rd_idx] && !hole_found) begin
            hole_found <= 1'b1;
            hole_idx   <= rd_idx;
          end
          if (done) begin
            state    <= ST_IDLE;
            out_q    <= res;
            m_tvalid <= 1'b1;
            rd_vld   <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_scan_out_empty, state == ST_SCAN, !m_tvalid,
               "result register busy during scan")
  `ASSERT_NEXT(a_valid_monotonic, 1'b1,
               $countones(entry_valid) >= $past($countones(entry_valid)),
               "cache entry lost its valid bit")
  `ASSERT_IMPL(a_single_write, wr_en, state == ST_SCAN && cur.kind == arp_pkg::KIND_LEARN,
               "cache write outside a learn scan")

endmodule
